[hdl/sfr_pkg.sv]
// ---------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the status frame receiver: request codes,
// result status codes, parser phases, sequencer states and frame constants.
// ---------------------------------------------------------------------------
package sfr_pkg;

  // request codes on req_type
  localparam logic [1:0] REQ_BYTE    = 2'd0;
  localparam logic [1:0] REQ_TIMEOUT = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_PING      = 3'd1;
  localparam logic [2:0] ST_SLAVE_ERR = 3'd2;
  localparam logic [2:0] ST_BAD_INST  = 3'd3;
  localparam logic [2:0] ST_CRC       = 3'd4;
  localparam logic [2:0] ST_LENGTH    = 3'd5;
  localparam logic [2:0] ST_TIMEOUT   = 3'd6;
  localparam logic [2:0] ST_RANGE     = 3'd7;

  // configuration register index (paddr[2])
  localparam logic CFG_TABLE_SIZE = 1'b0;
  localparam logic [7:0] TABLE_SIZE_RESET = 8'd251;

  // frame constants
  localparam logic [15:0] CRC_POLY    = 16'h8005;
  localparam logic [7:0]  HDR_BYTE    = 8'hFF;
  localparam logic [7:0]  INST_STATUS = 8'h55;
  localparam logic [7:0]  LEN_MIN     = 8'd3;
  localparam logic [7:0]  LEN_MAX     = 8'd250;
  localparam logic [7:0]  PING_CRC_HI = 8'hFE;
  localparam logic [7:0]  PING_CRC_LO = 8'h56;
  localparam logic [7:0]  PING_LEN    = 8'd4;
  localparam logic [7:0]  HDR_BYTES   = 8'd5;  // inst, err, start, crc hi, crc lo
  localparam logic [7:0]  DATA_OFFSET = 8'd3;  // first data byte in the body

  // body buffer
  localparam int BUF_DEPTH = 256;
  localparam int BUF_AW    = 8;

  // receive parser phase
  typedef enum logic [1:0] {
    PH_HDR1,
    PH_HDR2,
    PH_LEN,
    PH_BODY
  } phase_t;

  // sequencer state
  typedef enum logic [2:0] {
    S_IDLE,
    S_CRC,
    S_FINISH,
    S_COPY_RD,
    S_COPY_WR,
    S_TBL_RD,
    S_EMIT
  } state_t;

endpackage

[hdl/sfr_ram.sv]
// ---------------------------------------------------------------------------
// sfr_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
module sfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[hdl/status_frame_receiver_unit.sv]
// ---------------------------------------------------------------------------
// status_frame_receiver_unit
// Status frame parser: hunts FF FF, takes a length byte and the body, runs
// CRC-16 (0x8005) one bit per cycle and copies data bytes into the table.
// ---------------------------------------------------------------------------
// Steps: header, timeout and unknown beats go from idle to the emit state;
// a valid length byte and body bytes first pass the bit-serial CRC state; an
// in-range table read passes the table read state. A frame's last byte adds a
// finish state and a copy pass per copied data byte (one body-buffer read and one table write per byte).
// Throughput: one beat in flight; the next is taken once the result is loaded.
// Reset: parser hunts the first header byte, table reads as zero at once
// through per-entry valid bits; no clearing pass.
// ---------------------------------------------------------------------------
module status_frame_receiver_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst,
  // item channel
  input  logic        item_valid,
  output logic        item_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  rx_byte,
  input  logic [7:0]  read_address,
  // result channel
  output logic        result_valid,
  input  logic        result_stall,
  output logic        frame_done,
  output logic [2:0]  status,
  output logic [7:0]  slave_error,
  output logic [7:0]  table_start,
  output logic [7:0]  written_count,
  output logic [7:0]  read_data,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  import sfr_pkg::*;

  localparam int TAW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [8:0] TBL_LIMIT = 9'(TABLE_DEPTH);

  // control state
  state_t      state, state_next;
  phase_t      phase;
  logic [7:0]  table_size;
  logic [7:0]  frame_length;
  logic [7:0]  body_count;
  logic [15:0] crc;
  logic [2:0]  bit_cnt;
  logic        last_byte;
  logic [7:0]  copy_idx;
  logic [TABLE_DEPTH-1:0] tbl_valid;

  // captured body fields
  logic [7:0]  f_inst, f_err, f_start, f_b3;

  // working result
  logic        res_done;
  logic [2:0]  res_status;
  logic [7:0]  res_slave_error, res_start, res_count, res_read_data;
  logic        rd_valid;

  // handshakes
  logic accept, out_free, cfg_write;
  assign item_stall = (state != S_IDLE);
  assign accept     = item_valid && !item_stall;
  assign out_free   = !result_valid || !result_stall;
  assign pready     = 1'b1;
  assign cfg_write  = psel && penable && pwrite && pready;

  // register read-back
  always_comb begin
    prdata = '0;
    if (paddr[2] == CFG_TABLE_SIZE) begin
      prdata = {24'd0, table_size};
    end
  end

  // byte classification
  logic len_ok, rd_in_range;
  logic timeout_beat, badlen_beat;
  logic [7:0] count_inc;
  assign len_ok       = (rx_byte >= LEN_MIN) && (rx_byte <= LEN_MAX);
  assign rd_in_range  = ({1'b0, read_address} < TBL_LIMIT);
  assign count_inc    = body_count + 8'd1;
  assign timeout_beat = accept && (req_type == REQ_TIMEOUT);
  assign badlen_beat  = accept && (req_type == REQ_BYTE) && (phase == PH_LEN) && !len_ok;

  // one CRC bit step, the shared shift unit
  logic [15:0] crc_step;
  assign crc_step = crc[15] ? ({crc[14:0], 1'b0} ^ CRC_POLY) : {crc[14:0], 1'b0};

  // end-of-frame evaluation
  logic       range_fail, ping, go_copy;
  logic [7:0] copy_count;
  logic [2:0] fin_status;
  assign range_fail = ({1'b0, f_start} + {1'b0, frame_length}) >=
                      (9'd4 + {1'b0, table_size});
  assign ping       = (frame_length == PING_LEN) && (f_start == PING_CRC_HI) &&
                      (f_b3 == PING_CRC_LO);
  assign copy_count = (frame_length >= HDR_BYTES) ? (frame_length - HDR_BYTES) : 8'd0;

  always_comb begin
    if (crc != 16'd0) begin
      fin_status = ST_CRC;
    end else if (f_inst != INST_STATUS) begin
      fin_status = ST_BAD_INST;
    end else if (f_err != 8'd0) begin
      fin_status = ST_SLAVE_ERR;
    end else if (ping) begin
      fin_status = ST_PING;
    end else if (range_fail) begin
      fin_status = ST_RANGE;
    end else begin
      fin_status = ST_OK;
    end
  end
  assign go_copy = (fin_status == ST_OK) && (copy_count != 8'd0);

  // copy addressing
  logic [8:0] wr_sum;
  logic       wr_in_range, copy_end;
  assign wr_sum      = {1'b0, res_start} + {1'b0, copy_idx};
  assign wr_in_range = (wr_sum < TBL_LIMIT);
  assign copy_end    = ((copy_idx + 8'd1) == res_count);

  // body buffer
  logic             buf_we;
  logic [BUF_AW-1:0] buf_raddr;
  logic [7:0]       buf_rdata;
  assign buf_we    = accept && (req_type == REQ_BYTE) && (phase == PH_BODY);
  assign buf_raddr = BUF_AW'(copy_idx + DATA_OFFSET);

  sfr_ram #(.WIDTH(8), .DEPTH(BUF_DEPTH)) u_body_buf (
    .clk   (clk),
    .we    (buf_we),
    .waddr (body_count),
    .wdata (rx_byte),
    .raddr (buf_raddr),
    .rdata (buf_rdata)
  );

  // mirrored table
  logic           tbl_we;
  logic [TAW-1:0] tbl_waddr;
  logic [7:0]     tbl_rdata;
  assign tbl_we    = (state == S_COPY_WR) && wr_in_range;
  assign tbl_waddr = wr_sum[TAW-1:0];

  sfr_ram #(.WIDTH(8), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (buf_rdata),
    .raddr (read_address[TAW-1:0]),
    .rdata (tbl_rdata)
  );

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EMIT;
          if (req_type == REQ_BYTE) begin
            if (phase == PH_BODY || (phase == PH_LEN && len_ok)) begin
              state_next = S_CRC;
            end
          end else if (req_type == REQ_READ && rd_in_range) begin
            state_next = S_TBL_RD;
          end
        end
      end
      S_CRC: begin
        if (bit_cnt == 3'd7) begin
          state_next = last_byte ? S_FINISH : S_EMIT;
        end
      end
      S_FINISH:  state_next = go_copy ? S_COPY_RD : S_EMIT;
      S_COPY_RD: state_next = S_COPY_WR;
      S_COPY_WR: state_next = copy_end ? S_EMIT : S_COPY_RD;
      S_TBL_RD:  state_next = S_EMIT;
      S_EMIT:    state_next = out_free ? S_IDLE : S_EMIT;
      default:   state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // parser and datapath control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR1;
      frame_length <= 8'd0;
      body_count   <= 8'd0;
      crc          <= 16'd0;
      bit_cnt      <= 3'd0;
      last_byte    <= 1'b0;
      copy_idx     <= 8'd0;
      table_size   <= TABLE_SIZE_RESET;
      tbl_valid    <= '0;
    end else begin
      if (cfg_write && paddr[2] == CFG_TABLE_SIZE) begin
        table_size <= pwdata[7:0];
      end
      case (state)
        S_IDLE: begin
          bit_cnt  <= 3'd0;
          copy_idx <= 8'd0;
          if (accept && req_type == REQ_TIMEOUT) begin
            phase <= PH_HDR1;
          end else if (accept && req_type == REQ_BYTE) begin
            case (phase)
              PH_HDR1: begin
                if (rx_byte == HDR_BYTE) begin
                  phase <= PH_HDR2;
                end
              end
              PH_HDR2: phase <= (rx_byte == HDR_BYTE) ? PH_LEN : PH_HDR1;
              PH_LEN: begin
                if (len_ok) begin
                  frame_length <= rx_byte;
                  body_count   <= 8'd0;
                  crc          <= {rx_byte, 8'd0};
                  last_byte    <= 1'b0;
                  phase        <= PH_BODY;
                end else begin
                  phase <= PH_HDR1;
                end
              end
              default: begin
                crc        <= crc ^ {rx_byte, 8'd0};
                body_count <= count_inc;
                last_byte  <= (count_inc >= frame_length);
                if (count_inc >= frame_length) begin
                  phase <= PH_HDR1;
                end
              end
            endcase
          end
        end
        S_CRC: begin
          crc     <= crc_step;
          bit_cnt <= bit_cnt + 3'd1;
        end
        S_COPY_WR: begin
          copy_idx <= copy_idx + 8'd1;
          if (wr_in_range) begin
            tbl_valid[tbl_waddr] <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // body field capture and working result
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        res_done        <= timeout_beat || badlen_beat;
        res_status      <= timeout_beat ? ST_TIMEOUT : (badlen_beat ? ST_LENGTH : ST_OK);
        res_slave_error <= 8'd0;
        res_start       <= 8'd0;
        res_count       <= 8'd0;
        res_read_data   <= 8'd0;
        rd_valid        <= rd_in_range && tbl_valid[read_address[TAW-1:0]];
        if (buf_we) begin
          case (body_count)
            8'd0:    f_inst  <= rx_byte;
            8'd1:    f_err   <= rx_byte;
            8'd2:    f_start <= rx_byte;
            8'd3:    f_b3    <= rx_byte;
            default: ;
          endcase
        end
      end
      S_FINISH: begin
        res_done        <= 1'b1;
        res_status      <= fin_status;
        res_slave_error <= (fin_status == ST_SLAVE_ERR) ? f_err : 8'd0;
        res_start       <= (fin_status == ST_OK || fin_status == ST_RANGE) ? f_start : 8'd0;
        res_count       <= (fin_status == ST_OK) ? copy_count : 8'd0;
      end
      S_TBL_RD: begin
        res_read_data <= rd_valid ? tbl_rdata : 8'd0;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_EMIT && out_free) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      frame_done    <= res_done;
      status        <= res_status;
      slave_error   <= res_slave_error;
      table_start   <= res_start;
      written_count <= res_count;
      read_data     <= res_read_data;
    end
  end

endmodule

[hdl/sfr_checker.sv]
// ---------------------------------------------------------------------------
// sfr_checker
// Port-level checks on the status frame receiver, bound to the top level.
// ---------------------------------------------------------------------------
module sfr_checker (
  input logic       clk,
  input logic       rst,
  input logic       item_valid,
  input logic       item_stall,
  input logic       result_valid,
  input logic       result_stall,
  input logic       frame_done,
  input logic [2:0] status,
  input logic [7:0] slave_error,
  input logic [7:0] read_data
);

  import sfr_pkg::*;

  // a stalled result beat holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(status) &&
    $stable(read_data))
    else $error("stalled result beat changed");

  // one item at a time: busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> item_stall)
    else $error("item accepted while previous still in work");

  // a nonzero status only ends a frame
  a_status_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && status != ST_OK |-> frame_done)
    else $error("status without frame_done");

  // read data never rides on a frame result
  a_read_no_frame: assert property (@(posedge clk) disable iff (rst)
    result_valid && read_data != 8'd0 |-> !frame_done)
    else $error("read data on a frame result");

  // slave error byte only with its status
  a_slave_err: assert property (@(posedge clk) disable iff (rst)
    result_valid && slave_error != 8'd0 |-> status == ST_SLAVE_ERR)
    else $error("slave error byte with wrong status");

endmodule

bind status_frame_receiver_unit sfr_checker u_sfr_checker (
  .clk          (clk),
  .rst          (rst),
  .item_valid   (item_valid),
  .item_stall   (item_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .frame_done   (frame_done),
  .status       (status),
  .slave_error  (slave_error),
  .read_data    (read_data)
);
